@@ sv/assert_macros.svh @@
// Assertion macros used by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

@@ sv/lsac_pkg.sv @@
// Types and codes of the set-associative cache tag model
`default_nettype none
package lsac_pkg;
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_IFETCH = 2'd3;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic        eviction;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
		logic        last;
	} rsp_t;
endpackage
`default_nettype wire

@@ sv/lsac_ram.sv @@
// Simple dual-port RAM with registered read
`default_nettype none
module lsac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ sv/lru_set_assoc_cache_sim.sv @@
// A load or store looks up in LK1, a modify in LK1 and then LK2; results are registered.
// A fetch is accepted but does no lookup and gives no result; busy blocks new requests.
// Each lookup reads a set row from the line RAM, compares the active ways and writes it back.
// The strobe is high for one cycle per result; a modify gives two; the receiver cannot stall.
// Reset clears counters and per-set valid flags at once; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module lru_set_assoc_cache_sim #(
	parameter int MAX_SET_BITS = 8,
	parameter int WAYS         = 8,
	parameter int STAMP_WIDTH  = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire lsac_pkg::req_t req,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [5:0]     cfg_data,
	output logic                rsp_valid,
	output lsac_pkg::rsp_t      rsp
);
	import lsac_pkg::*;

	localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NSETS   = 1 << MAX_SET_BITS;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W   = 1 + 64 + STAMP_WIDTH;
	localparam int VLD_B   = ENT_W - 1;
	localparam int TAG_LSB = STAMP_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LK1  = 2'd1;
	localparam logic [1:0] ST_LK2  = 2'd2;

	logic [1:0] state_q;
	logic [3:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;
	logic [STAMP_WIDTH-1:0] stamp_q;
	logic [31:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [NSETS-1:0] row_vld_q;

	logic [SET_W-1:0] set_s1;
	logic [63:0] tag_s1;
	logic modify_s1;
	logic rv_s1;
	logic [WAYS-1:0][ENT_W-1:0] row_q;

	logic accept, data_acc;
	logic [3:0] sb_eff;
	logic [6:0] tag_sh;
	logic [63:0] shifted;
	logic [SET_W-1:0] set_mask, set_c;
	logic [63:0] tag_c;
	logic [5:0] ways_eff;

	logic lk;
	logic [WAYS-1:0][ENT_W-1:0] rdata, src, new_row;
	logic [WAYS-1:0] act, vic_hot;
	logic hit, has_free;
	logic [WAY_W-1:0] hit_idx, free_idx, vic_idx, tgt;
	logic evict;

	assign busy      = (state_q != ST_IDLE);
	// registers only change between transactions
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign data_acc  = accept && (req.cmd != CMD_IFETCH);
	assign lk        = (state_q == ST_LK1) || (state_q == ST_LK2);

	// address split
	always_comb begin
		sb_eff   = (set_bits_q > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_q;
		shifted  = req.address >> block_bits_q;
		set_mask = ~({SET_W{1'b1}} << sb_eff);
		set_c    = shifted[SET_W-1:0] & set_mask;
		tag_sh   = 7'(sb_eff) + 7'(block_bits_q);
		tag_c    = tag_sh[6] ? 64'd0 : (req.address >> tag_sh[5:0]);
	end

	always_comb begin
		if (ways_q == 4'd0) begin
			ways_eff = 6'd1;
		end else if (6'(ways_q) > 6'(WAYS)) begin
			ways_eff = 6'(WAYS);
		end else begin
			ways_eff = 6'(ways_q);
		end
	end

	lsac_ram #(
		.WIDTH(WAYS * ENT_W),
		.DEPTH(NSETS)
	) u_line_ram (
		.clk   (clk),
		.we    (lk),
		.waddr (set_s1),
		.wdata (new_row),
		.raddr (set_c),
		.rdata (rdata)
	);

	// lookup over the row; second lookup of a modify works on the row just written
	always_comb begin
		src = (state_q == ST_LK2) ? row_q : (rv_s1 ? rdata : '0);
		for (int i = 0; i < WAYS; i++) begin
			act[i] = (6'(i) < ways_eff);
		end
		hit = 1'b0;
		hit_idx = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (act[i] && src[i][VLD_B] && (src[i][TAG_LSB +: 64] == tag_s1)) begin
				hit = 1'b1;
				hit_idx = WAY_W'(i);
			end
			if (act[i] && !src[i][VLD_B]) begin
				has_free = 1'b1;
				free_idx = WAY_W'(i);
			end
		end
		// oldest stamp, lowest way on a tie
		for (int i = 0; i < WAYS; i++) begin
			vic_hot[i] = act[i];
			for (int j = 0; j < WAYS; j++) begin
				if (j != i && act[j]) begin
					if (j < i) begin
						vic_hot[i] = vic_hot[i] &&
							(src[i][STAMP_WIDTH-1:0] < src[j][STAMP_WIDTH-1:0]);
					end else begin
						vic_hot[i] = vic_hot[i] &&
							(src[i][STAMP_WIDTH-1:0] <= src[j][STAMP_WIDTH-1:0]);
					end
				end
			end
		end
		vic_idx = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (vic_hot[i]) begin
				vic_idx = vic_idx | WAY_W'(i);
			end
		end
		evict = !hit && !has_free;
		tgt = hit ? hit_idx : (has_free ? free_idx : vic_idx);
		new_row = src;
		if (hit) begin
			new_row[tgt][STAMP_WIDTH-1:0] = stamp_q;
		end else begin
			new_row[tgt] = {1'b1, tag_s1, stamp_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			set_bits_q   <= 4'd0;
			block_bits_q <= 6'd0;
			ways_q       <= 4'd1;
			stamp_q      <= '0;
			hit_cnt_q    <= 32'd0;
			miss_cnt_q   <= 32'd0;
			evict_cnt_q  <= 32'd0;
			row_vld_q    <= '0;
			rsp_valid    <= 1'b0;
		end else begin
			rsp_valid <= lk;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
					REG_BLOCK_BITS: block_bits_q <= cfg_data;
					REG_WAYS:       ways_q       <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (data_acc) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if (lk) begin
				row_vld_q[set_s1] <= 1'b1;
				hit_cnt_q   <= hit_cnt_q + 32'(hit);
				miss_cnt_q  <= miss_cnt_q + 32'(!hit);
				evict_cnt_q <= evict_cnt_q + 32'(evict);
			end
			unique case (state_q)
				ST_IDLE: if (data_acc) state_q <= ST_LK1;
				ST_LK1:  state_q <= modify_s1 ? ST_LK2 : ST_IDLE;
				ST_LK2:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			set_s1    <= set_c;
			tag_s1    <= tag_c;
			modify_s1 <= (req.cmd == CMD_MODIFY);
			rv_s1     <= row_vld_q[set_c];
		end
		if (lk) begin
			row_q              <= new_row;
			rsp.hit            <= hit;
			rsp.miss           <= !hit;
			rsp.eviction       <= evict;
			rsp.hit_total      <= hit_cnt_q + 32'(hit);
			rsp.miss_total     <= miss_cnt_q + 32'(!hit);
			rsp.eviction_total <= evict_cnt_q + 32'(evict);
			rsp.last           <= (state_q == ST_LK2) || !modify_s1;
		end
	end

	`ASSERT_IMPL(a_hit_xor_miss, clk, arst_n, rsp_valid |-> (rsp.hit ^ rsp.miss))
	`ASSERT_IMPL(a_evict_on_miss, clk, arst_n, (rsp_valid && rsp.eviction) |-> rsp.miss)
	`ASSERT_NEXT(a_second_lookup, clk, arst_n, rsp_valid && !rsp.last, rsp_valid && rsp.last)
	`ASSERT_IMPL(a_strobe_busy, clk, arst_n, rsp_valid |-> $past(busy))
endmodule
`default_nettype wire

@@ tb/tb_lru_set_assoc_cache_sim.sv @@
// Self-checking testbench for the set-associative LRU cache tag model
`timescale 1ns / 1ps
`default_nettype none
module tb_lru_set_assoc_cache_sim;
	import lsac_pkg::*;

	localparam int MAX_SB = 8;
	localparam int NWAYS  = 8;
	localparam int NSETS  = 1 << MAX_SB;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	req_t           req;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [1:0]     cfg_index;
	logic [5:0]     cfg_data;
	logic           rsp_valid;
	rsp_t           rsp;

	lru_set_assoc_cache_sim dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// shadow cache state
	logic [63:0] tag_mem [NSETS*NWAYS];
	logic        vld_mem [NSETS*NWAYS];
	logic [31:0] stamp_mem [NSETS*NWAYS];
	logic [31:0] stamp_ctr, hits, misses, evicts;
	logic [3:0]  r_set_bits;
	logic [5:0]  r_block_bits;
	logic [3:0]  r_ways;

	rsp_t lookup_q [$];
	int   n_errors;
	// recently used addresses for reuse, so hits and evictions are frequent
	logic [63:0] addr_pool [$];

	function automatic rsp_t do_lookup(int set_idx, logic [63:0] tg, logic is_last);
		int nw, base, free_way, victim, idx;
		logic found, ev;
		rsp_t r;
		nw = (r_ways == 0) ? 1 : (r_ways > NWAYS ? NWAYS : r_ways);
		base = set_idx * NWAYS;
		free_way = -1;
		victim = 0;
		found = 1'b0;
		for (int w = 0; w < nw; w++) begin
			idx = base + w;
			if (vld_mem[idx] && tag_mem[idx] == tg) begin
				found = 1'b1;
				stamp_mem[idx] = stamp_ctr;
				break;
			end
			if (free_way < 0 && !vld_mem[idx]) free_way = w;
			if (vld_mem[idx] && stamp_mem[idx] < stamp_mem[base+victim]) victim = w;
		end
		ev = 1'b0;
		if (found) begin
			hits++;
		end else begin
			ev = (free_way < 0);
			idx = base + (ev ? victim : free_way);
			misses++;
			if (ev) evicts++;
			tag_mem[idx] = tg;
			stamp_mem[idx] = stamp_ctr;
			vld_mem[idx] = 1'b1;
		end
		r.hit = found;
		r.miss = !found;
		r.eviction = ev;
		r.hit_total = hits;
		r.miss_total = misses;
		r.eviction_total = evicts;
		r.last = is_last;
		return r;
	endfunction

	function automatic void predict_access(req_t a);
		int sb, set_idx, sh;
		logic [63:0] tg, s;
		if (a.cmd == CMD_IFETCH) return;
		sb = (r_set_bits > MAX_SB) ? MAX_SB : r_set_bits;
		s = (r_block_bits >= 64) ? 64'd0 : (a.address >> r_block_bits);
		set_idx = int'(s & ((64'd1 << sb) - 1));
		sh = sb + r_block_bits;
		tg = (sh >= 64) ? 64'd0 : (a.address >> sh);
		stamp_ctr++;
		if (a.cmd == CMD_MODIFY) begin
			lookup_q.push_back(do_lookup(set_idx, tg, 1'b0));
			lookup_q.push_back(do_lookup(set_idx, tg, 1'b1));
		end else begin
			lookup_q.push_back(do_lookup(set_idx, tg, 1'b1));
		end
	endfunction

	// results are checked on the edge that ends the strobe cycle
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid) begin
			if (lookup_q.size() == 0) begin
				$error("unexpected result transaction");
				n_errors++;
			end else begin
				e = lookup_q.pop_front();
				if (rsp.hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, rsp.hit); n_errors++;
				end
				if (rsp.miss !== e.miss) begin
					$error("miss: expected %0d, got %0d", e.miss, rsp.miss); n_errors++;
				end
				if (rsp.eviction !== e.eviction) begin
					$error("eviction: expected %0d, got %0d", e.eviction, rsp.eviction);
					n_errors++;
				end
				if (rsp.hit_total !== e.hit_total) begin
					$error("hit_total: expected %0d, got %0d", e.hit_total, rsp.hit_total);
					n_errors++;
				end
				if (rsp.miss_total !== e.miss_total) begin
					$error("miss_total: expected %0d, got %0d", e.miss_total, rsp.miss_total);
					n_errors++;
				end
				if (rsp.eviction_total !== e.eviction_total) begin
					$error("eviction_total: expected %0d, got %0d", e.eviction_total,
						rsp.eviction_total);
					n_errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, rsp.last); n_errors++;
				end
			end
		end
	end

	// sender: bursts of random length, mostly separated by random gaps
	int burst_left;

	task automatic send_access(logic [1:0] c, logic [63:0] a);
		req_t t;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		t.cmd = c;
		t.address = a;
		start <= 1'b1;
		req <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_access(t);
		if (c != CMD_IFETCH) begin
			addr_pool.push_back(a);
			if (addr_pool.size() > 24) void'(addr_pool.pop_front());
		end
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		start <= 1'b0;
		while (lookup_q.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SET_BITS:   r_set_bits = val[3:0];
			REG_BLOCK_BITS: r_block_bits = val;
			REG_WAYS:       r_ways = val[3:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [5:0] sb, logic [5:0] bb, logic [5:0] nw);
		drain();
		write_reg(REG_SET_BITS, sb);
		write_reg(REG_BLOCK_BITS, bb);
		write_reg(REG_WAYS, nw);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [1:0] rand_cmd();
		return 2'($urandom_range(0, 3));
	endfunction

	function automatic logic [63:0] rand_addr();
		logic [63:0] a;
		a = {$urandom, $urandom};
		if (addr_pool.size() != 0 && $urandom_range(0, 2) != 0) begin
			a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
			// flip the low four address bits now and then: same line when block bits cover them
			if ($urandom_range(0, 1)) a[3:0] = 4'($urandom);
		end else if ($urandom_range(0, 1)) begin
			a = 64'($urandom_range(0, 4095));
		end
		return a;
	endfunction

	task automatic test_reset_defaults;
		// one set, one way, whole address is tag
		send_access(CMD_LOAD, 64'd0);
		send_access(CMD_LOAD, 64'd0);
		send_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(CMD_MODIFY, 64'd0);
		send_access(CMD_IFETCH, 64'h1234);
		send_access(CMD_MODIFY, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_directed_lru;
		configure(6'd2, 6'd4, 6'd2);
		// four tags on set 0 with two ways: fill, hit, evict oldest
		send_access(CMD_LOAD, 64'h000);
		send_access(CMD_LOAD, 64'h040);
		send_access(CMD_STORE, 64'h000);
		send_access(CMD_LOAD, 64'h080);
		send_access(CMD_LOAD, 64'h040);
		send_access(CMD_MODIFY, 64'h0C0);
		send_access(CMD_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(CMD_LOAD, 64'h010);
	endtask

	task automatic test_register_extremes;
		// oversize set bits, zero ways, large shift so tag collapses to zero
		configure(6'd15, 6'd63, 6'd0);
		send_access(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(CMD_LOAD, 64'd1);
		configure(6'd8, 6'd56, 6'd15);
		send_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(CMD_MODIFY, 64'h0100_0000_0000_0000);
		configure(6'd0, 6'd32, 6'd8);
		send_access(CMD_LOAD, 64'hFFFF_FFFF_0000_0000);
		send_access(CMD_LOAD, 64'h0000_0000_FFFF_FFFF);
		// unused register index is ignored
		drain();
		write_reg(2'd3, 6'h3F);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_random_phases;
		logic [5:0] sb, bb, nw;
		for (int ph = 0; ph < 8; ph++) begin
			sb = 6'($urandom_range(0, 10));
			bb = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 6));
			nw = 6'($urandom_range(0, 15));
			if (ph == 0) begin sb = 6'd1; bb = 6'd0; nw = 6'd1; end
			if (ph == 1) begin sb = 6'd0; bb = 6'd2; nw = 6'd8; end
			configure(sb, bb, nw);
			addr_pool.delete();
			repeat (150) send_access(rand_cmd(), rand_addr());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_errors = 0;
		burst_left = 0;
		stamp_ctr = '0; hits = '0; misses = '0; evicts = '0;
		r_set_bits = '0; r_block_bits = '0; r_ways = 4'd1;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			vld_mem[i] = 1'b0;
			stamp_mem[i] = '0;
			tag_mem[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_lru();
		test_register_extremes();
		test_random_phases();
		drain();
		if (n_errors == 0 && lookup_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (lookup_q.size() != 0) $error("%0d results never arrived", lookup_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
